// ===== sv/otr_pkg.sv =====
// shared types, constants and helpers of the overwriting event trace ring
`default_nettype none

package otr_pkg;

   // ring geometry
   localparam int DEPTH  = 64;
   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;

   // fixed field widths
   localparam int FUNC_W    = 2;
   localparam int SHARD_W   = 16;
   localparam int WORD_W    = 64;
   localparam int PAYLOAD_W = 32;
   localparam int FILL_W    = 7;

   // stream packing
   localparam int REQ_DATA_W = 240;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 312;
   localparam int RSP_USER_W = 2;

   // request codes
   localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SINCE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_ALL    = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } fsm_state_type;

   // one stored event
   typedef struct packed {
      logic [WORD_W-1:0]        sequence_no;
      logic [SHARD_W-1:0]       shard;
      logic [WORD_W-1:0]        lamport;
      logic signed [WORD_W-1:0] stamp;
      logic [PAYLOAD_W-1:0]     payload;
   } entry_type;

   // one incoming item
   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic [SHARD_W-1:0]       shard;
      logic [WORD_W-1:0]        lamport;
      logic signed [WORD_W-1:0] stamp;
      logic [PAYLOAD_W-1:0]     payload;
      logic [WORD_W-1:0]        mark;
   } req_type;

   // one outgoing item
   typedef struct packed {
      entry_type           ev;
      logic                has_event;
      logic                complete;
      logic                last;
      logic [FILL_W-1:0]   fill_count;
      logic [WORD_W-1:0]   total_appended;
   } rsp_type;

   // ram access of one cycle
   typedef struct packed {
      logic              we;
      logic [PTR_W-1:0]  waddr;
      entry_type         wdata;
      logic              re;
      logic [PTR_W-1:0]  raddr;
   } ram_req_type;

   // pointer step with wrap at the ring depth
   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] res;
      if (ptr == PTR_W'(DEPTH - 1)) begin
         res = '0;
      end else begin
         res = ptr + PTR_W'(1);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== sv/otr_ram.sv =====
// event store: one write port, one registered read port
`default_nettype none

module otr_ram (
   input  wire logic                 clock,
   input  wire otr_pkg::ram_req_type ram_req,
   output otr_pkg::entry_type        rd_data
);
   import otr_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
   end

   // read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (ram_req.re) begin
         rd_data_ff <= mem[ram_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/otr_obuf.sv =====
// output register between the sequencer and the result stream
`default_nettype none

module otr_obuf (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire otr_pkg::rsp_type push_data,
   output logic                  can_push,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output otr_pkg::rsp_type      out_data
);
   import otr_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign can_push = !valid_ff || out_ready;

   // hold until taken, refill in the same cycle
   always_comb begin
      valid_in = valid_ff;
      if (push) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff <= push_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== sv/otr_seq.sv =====
// sequencer: appends into the ring and walks it for replays
`default_nettype none

module otr_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire otr_pkg::req_type     req,
   output otr_pkg::ram_req_type      ram_req,
   input  wire otr_pkg::entry_type   rd_data,
   input  wire logic                 can_push,
   output logic                      push,
   output otr_pkg::rsp_type          push_data
);
   import otr_pkg::*;

   fsm_state_type state_ff, state_in;

   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [CNT_W-1:0]  held_ff, held_in;
   logic [WORD_W-1:0] total_ff, total_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  off_ff, off_in;
   logic              rd_valid_ff, rd_valid_in;
   logic              pend_valid_ff, pend_valid_in;
   entry_type         pend_ff, pend_in;
   logic              comp_ff, comp_in;
   logic              first_ff, first_in;
   logic              all_ff, all_in;
   logic [WORD_W-1:0] mark_ff, mark_in;
   logic [WORD_W-1:0] mark_inc_ff, mark_inc_in;

   logic              accept;
   logic              is_replay;
   logic [WORD_W-1:0] total_inc;
   logic [CNT_W-1:0]  held_after;
   logic [SUM_W-1:0]  old_sum;
   logic [PTR_W-1:0]  oldest;
   logic              hit;
   logic              comp_first;
   logic              emit_mid;
   logic              consume;
   logic              issue;
   logic              scan_done;

   // shared terms
   assign accept     = req_valid && req_ready;
   assign is_replay  = (req.func == FUNC_SINCE) || (req.func == FUNC_ALL);
   assign total_inc  = total_ff + WORD_W'(1);
   assign held_after = (held_ff == CNT_W'(DEPTH)) ? held_ff : held_ff + CNT_W'(1);
   assign old_sum    = SUM_W'(wp_ff) + SUM_W'(DEPTH) - SUM_W'(held_ff);
   assign oldest     = (old_sum >= SUM_W'(DEPTH)) ? PTR_W'(old_sum - SUM_W'(DEPTH))
                                                  : PTR_W'(old_sum);

   // scan step: test the entry in the read register, fetch the next one
   assign hit        = all_ff || (rd_data.lamport > mark_ff);
   assign comp_first = all_ff || (&mark_ff) || (rd_data.lamport <= mark_inc_ff);
   assign emit_mid   = (state_ff == ST_SCAN) && rd_valid_ff && hit && pend_valid_ff
                       && can_push;
   assign consume    = (state_ff == ST_SCAN) && rd_valid_ff
                       && (!(hit && pend_valid_ff) || can_push);
   assign issue      = (state_ff == ST_SCAN) && (off_ff != held_ff)
                       && (!rd_valid_ff || consume);
   assign scan_done  = (off_ff == held_ff) && (!rd_valid_ff || consume);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && is_replay) begin
               state_in = (held_ff == '0) ? ST_FLUSH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (can_push) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready                = 1'b0;
      push                     = 1'b0;
      push_data                = '0;
      push_data.fill_count     = FILL_W'(held_ff);
      push_data.total_appended = total_ff;
      push_data.complete       = comp_ff;
      ram_req                  = '0;
      ram_req.waddr            = wp_ff;
      ram_req.raddr            = rd_ptr_ff;
      ram_req.wdata.sequence_no = total_inc;
      ram_req.wdata.shard      = req.shard;
      ram_req.wdata.lamport    = req.lamport;
      ram_req.wdata.stamp      = req.stamp;
      ram_req.wdata.payload    = req.payload;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = can_push;
            if (accept && (req.func == FUNC_APPEND)) begin
               ram_req.we                = 1'b1;
               push                      = 1'b1;
               push_data.ev.sequence_no  = total_inc;
               push_data.complete        = 1'b1;
               push_data.last            = 1'b1;
               push_data.fill_count      = FILL_W'(held_after);
               push_data.total_appended  = total_inc;
            end
         end
         ST_SCAN: begin
            ram_req.re          = issue;
            push                = emit_mid;
            push_data.ev        = pend_ff;
            push_data.has_event = 1'b1;
         end
         ST_FLUSH: begin
            push           = can_push;
            push_data.last = 1'b1;
            if (pend_valid_ff) begin
               push_data.ev        = pend_ff;
               push_data.has_event = 1'b1;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      wp_in         = wp_ff;
      held_in       = held_ff;
      total_in      = total_ff;
      rd_ptr_in     = rd_ptr_ff;
      off_in        = off_ff;
      rd_valid_in   = rd_valid_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      comp_in       = comp_ff;
      first_in      = first_ff;
      all_in        = all_ff;
      mark_in       = mark_ff;
      mark_inc_in   = mark_inc_ff;
      if (accept && (req.func == FUNC_APPEND)) begin
         wp_in    = ptr_inc(wp_ff);
         held_in  = held_after;
         total_in = total_inc;
      end else if (accept && is_replay) begin
         mark_in       = req.mark;
         mark_inc_in   = req.mark + WORD_W'(1);
         all_in        = (req.func == FUNC_ALL);
         off_in        = '0;
         rd_ptr_in     = oldest;
         rd_valid_in   = 1'b0;
         pend_valid_in = 1'b0;
         first_in      = 1'b1;
         comp_in       = 1'b1;
      end
      if (issue) begin
         rd_ptr_in = ptr_inc(rd_ptr_ff);
         off_in    = off_ff + CNT_W'(1);
      end
      if (issue) begin
         rd_valid_in = 1'b1;
      end else if (consume) begin
         rd_valid_in = 1'b0;
      end
      if (consume) begin
         first_in = 1'b0;
         if (first_ff) begin
            comp_in = comp_first;
         end
         if (hit) begin
            pend_in       = rd_data;
            pend_valid_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wp_ff         <= '0;
         held_ff       <= '0;
         total_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wp_ff         <= wp_in;
         held_ff       <= held_in;
         total_ff      <= total_in;
         rd_valid_ff   <= rd_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // scan payload registers
   always_ff @(posedge clock) begin
      rd_ptr_ff   <= rd_ptr_in;
      off_ff      <= off_in;
      pend_ff     <= pend_in;
      comp_ff     <= comp_in;
      first_ff    <= first_in;
      all_ff      <= all_in;
      mark_ff     <= mark_in;
      mark_inc_ff <= mark_inc_in;
   end

endmodule

`default_nettype wire

// ===== sv/overwriting_event_trace_ring_top.sv =====
// top level of the overwriting event trace ring
//
//   channel  dir  data                                          user                 last
//   req_     in   shard, lamport, time, payload, since mark     func                 -
//   rsp_     out  sequence, shard, lamport, time, payload,      has_event, complete  last
//                 fill count, total appended
//
// an append or unused code is taken in idle; appends stream at one per cycle unless results back up
// a replay holds the input while the ring is scanned and its last result is pushed:
// the single read port fetches one entry a cycle, and the scan stalls while the result register is full
// reset clears the write pointer, fill count and append total; the store is not cleared,
// only entries already written are ever read
// appends and replay reads never overlap, so the store needs no forwarding
`default_nettype none

module overwriting_event_trace_ring_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // ev_shard, ev_lamport, ev_time, ev_payload, since_mark
   input  wire logic [otr_pkg::REQ_DATA_W-1:0]   req_tdata,
   // func
   input  wire logic [otr_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // out_sequence, out_shard, out_clock, out_time, out_payload,
   // fill_count, total_appended, one zero pad bit
   output logic [otr_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // has_event, complete
   output logic [otr_pkg::RSP_USER_W-1:0]        rsp_tuser,
   output logic                                  rsp_tlast
);
   import otr_pkg::*;

   req_type     req;
   ram_req_type ram_req;
   entry_type   rd_data;
   logic        can_push;
   logic        push;
   rsp_type     push_data;
   rsp_type     rsp;

   // unpack the request item
   assign req.func    = req_tuser;
   assign req.shard   = req_tdata[15:0];
   assign req.lamport = req_tdata[79:16];
   assign req.stamp   = req_tdata[143:80];
   assign req.payload = req_tdata[175:144];
   assign req.mark    = req_tdata[239:176];

   otr_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .ram_req   (ram_req),
      .rd_data   (rd_data),
      .can_push  (can_push),
      .push      (push),
      .push_data (push_data)
   );

   otr_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   otr_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .can_push  (can_push),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp)
   );

   // pack the result item
   assign rsp_tdata = {1'b0, rsp.total_appended, rsp.fill_count, rsp.ev.payload,
                       rsp.ev.stamp, rsp.ev.lamport, rsp.ev.shard, rsp.ev.sequence_no};
   assign rsp_tuser = {rsp.complete, rsp.has_event};
   assign rsp_tlast = rsp.last;

   // fill count never passes the ring depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp.fill_count <= FILL_W'(DEPTH)))
      else $error("fill count above ring depth");

   // a result without an event always closes its request
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp.has_event) |-> rsp.last)
      else $error("empty result not marked last");

   // an accepted append shows its result in the next cycle
   a_append_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == FUNC_APPEND)) |=>
         (rsp_tvalid && rsp.last && !rsp.has_event))
      else $error("append result missing");

endmodule

`default_nettype wire

// ===== test/tb_overwriting_event_trace_ring_top.sv =====
// testbench of the overwriting event trace ring: directed and random items against a predictor
`default_nettype none

module tb_overwriting_event_trace_ring_top;

   import otr_pkg::*;

   localparam int CLK_PERIOD     = 8;
   localparam int TIMEOUT_CYCLES = 400_000;
   localparam int RANDOM_ITEMS   = 30;
   localparam int REPORT_LIMIT   = 10;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   // one result item as it leaves the ring
   typedef struct {
      logic [63:0]        seq_no;
      logic [15:0]        shard;
      logic [63:0]        lamport;
      logic signed [63:0] stamp;
      logic [31:0]        payload;
      logic               has_event;
      logic               complete;
      logic               is_last;
      logic [6:0]         fill;
      logic [63:0]        total;
   } trace_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;

   // predicted ring contents
   entry_type   ring_store [DEPTH];
   int          ring_wp     = 0;
   int          ring_held   = 0;
   logic [63:0] ring_total  = '0;

   trace_result_type pending_trace_results [$];

   // run bookkeeping
   int          mismatch_count = 0;
   int          results_seen   = 0;
   int          n_appends      = 0;
   int          n_replays      = 0;
   int          n_ignored      = 0;
   int          burst_left     = 0;
   bit          gaps_on        = 1'b0;
   int          stall_pct      = 0;
   int          hold_cycles_req = 0;
   logic [63:0] lamport_clock  = 64'd1000;

   overwriting_event_trace_ring_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // clock
   always begin
      #(CLK_PERIOD / 2) clock = 1'b1;
      #(CLK_PERIOD / 2) clock = 1'b0;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // expected results of one accepted item, ring state advanced
   function automatic void predict_trace_results(input logic [1:0] op,
                                                 input logic [15:0] shard,
                                                 input logic [63:0] lamport,
                                                 input logic signed [63:0] stamp,
                                                 input logic [31:0] payload,
                                                 input logic [63:0] mark);
      trace_result_type r;
      int            oldest;
      int            idx;
      int            picked;
      int            left;
      logic          comp;
      r.seq_no    = '0;
      r.shard     = '0;
      r.lamport   = '0;
      r.stamp     = '0;
      r.payload   = '0;
      r.has_event = 1'b0;
      r.complete  = 1'b1;
      r.is_last   = 1'b1;
      if (op == FUNC_APPEND) begin
         ring_total = ring_total + 64'd1;
         ring_store[ring_wp].sequence_no = ring_total;
         ring_store[ring_wp].shard       = shard;
         ring_store[ring_wp].lamport     = lamport;
         ring_store[ring_wp].stamp       = stamp;
         ring_store[ring_wp].payload     = payload;
         ring_wp = (ring_wp + 1) % DEPTH;
         if (ring_held < DEPTH) begin
            ring_held++;
         end
         r.seq_no = ring_total;
         r.fill   = 7'(ring_held);
         r.total  = ring_total;
         pending_trace_results.push_back(r);
      end else if (op == FUNC_SINCE || op == FUNC_ALL) begin
         r.fill  = 7'(ring_held);
         r.total = ring_total;
         if (ring_held == 0) begin
            pending_trace_results.push_back(r);
         end else begin
            oldest = (ring_wp + DEPTH - ring_held) % DEPTH;
            comp   = (op == FUNC_ALL) || (mark == '1) ||
                     (ring_store[oldest].lamport <= mark + 64'd1);
            // count the selection first so the final one can carry last
            picked = 0;
            for (int off = 0; off < ring_held; off++) begin
               idx = (oldest + off) % DEPTH;
               if (op == FUNC_ALL || ring_store[idx].lamport > mark) begin
                  picked++;
               end
            end
            if (picked == 0) begin
               r.complete = comp;
               pending_trace_results.push_back(r);
            end else begin
               left = picked;
               for (int off = 0; off < ring_held; off++) begin
                  idx = (oldest + off) % DEPTH;
                  if (op == FUNC_ALL || ring_store[idx].lamport > mark) begin
                     left--;
                     r.seq_no    = ring_store[idx].sequence_no;
                     r.shard     = ring_store[idx].shard;
                     r.lamport   = ring_store[idx].lamport;
                     r.stamp     = ring_store[idx].stamp;
                     r.payload   = ring_store[idx].payload;
                     r.has_event = 1'b1;
                     r.complete  = comp;
                     r.is_last   = (left == 0);
                     pending_trace_results.push_back(r);
                  end
               end
            end
         end
      end
   endfunction

   // offer one item, in bursts with random gaps when gaps are on, predict once accepted
   task automatic send_item(input logic [1:0] op, input logic [15:0] shard,
                            input logic [63:0] lamport, input logic signed [63:0] stamp,
                            input logic [31:0] payload, input logic [63:0] mark);
      int gap;
      if (gaps_on && burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 8);
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {mark, payload, stamp, lamport, shard};
      do @(posedge clock); while (!req_tready);
      predict_trace_results(op, shard, lamport, stamp, payload, mark);
      case (op)
         FUNC_APPEND: n_appends++;
         FUNC_UNUSED: n_ignored++;
         default:     n_replays++;
      endcase
   endtask

   task automatic send_append(input logic [15:0] shard, input logic [63:0] lamport,
                              input logic signed [63:0] stamp, input logic [31:0] payload);
      send_item(FUNC_APPEND, shard, lamport, stamp, payload, rand64());
   endtask

   // unused data fields of a replay carry random bits
   task automatic send_replay(input logic [1:0] op, input logic [63:0] mark);
      send_item(op, 16'($urandom), rand64(), rand64(), $urandom, mark);
   endtask

   task automatic send_random_append();
      logic [63:0] lam;
      if ($urandom_range(0, 9) < 8) begin
         lamport_clock = lamport_clock + 64'($urandom_range(1, 4));
         lam = lamport_clock;
      end else begin
         lam = rand64();
      end
      send_append(16'($urandom), lam, rand64(), $urandom);
   endtask

   // sender stops until every expected item has come back
   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      while (pending_trace_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic note_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("mismatch on result %0d, %s: expected %h, got %h",
                  results_seen, what, want, got);
      end
   endtask

   // receiver: random stall pattern, plus long hold-offs on request
   always @(posedge clock) begin : rsp_stall_gen
      int hold_left;
      if (hold_cycles_req != 0) begin
         hold_left       = hold_cycles_req;
         hold_cycles_req = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // result check against the oldest expectation
   always @(posedge clock) begin : rsp_check
      trace_result_type got;
      trace_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.seq_no    = rsp_tdata[63:0];
         got.shard     = rsp_tdata[79:64];
         got.lamport   = rsp_tdata[143:80];
         got.stamp     = rsp_tdata[207:144];
         got.payload   = rsp_tdata[239:208];
         got.fill      = rsp_tdata[246:240];
         got.total     = rsp_tdata[310:247];
         got.has_event = rsp_tuser[0];
         got.complete  = rsp_tuser[1];
         got.is_last   = rsp_tlast;
         results_seen++;
         if (pending_trace_results.size() == 0) begin
            note_mismatch("item with nothing expected, sequence", '0, got.seq_no);
         end else begin
            want = pending_trace_results.pop_front();
            if (got.seq_no !== want.seq_no)
               note_mismatch("sequence", want.seq_no, got.seq_no);
            if (got.shard !== want.shard)
               note_mismatch("shard", 64'(want.shard), 64'(got.shard));
            if (got.lamport !== want.lamport)
               note_mismatch("lamport", want.lamport, got.lamport);
            if (got.stamp !== want.stamp)
               note_mismatch("timestamp", want.stamp, got.stamp);
            if (got.payload !== want.payload)
               note_mismatch("payload", 64'(want.payload), 64'(got.payload));
            if (got.has_event !== want.has_event)
               note_mismatch("has_event", 64'(want.has_event), 64'(got.has_event));
            if (got.complete !== want.complete)
               note_mismatch("complete", 64'(want.complete), 64'(got.complete));
            if (got.is_last !== want.is_last)
               note_mismatch("last", 64'(want.is_last), 64'(got.is_last));
            if (got.fill !== want.fill)
               note_mismatch("fill count", 64'(want.fill), 64'(got.fill));
            if (got.total !== want.total)
               note_mismatch("total appended", want.total, got.total);
         end
      end
   end

   // replays and an unused code on a ring that holds nothing
   task automatic test_empty_ring();
      send_replay(FUNC_SINCE, '0);
      send_replay(FUNC_ALL, rand64());
      send_replay(FUNC_SINCE, '1);
      send_replay(FUNC_UNUSED, rand64());
      wait_for_idle();
   endtask

   // field extremes and the completeness edges of replay-since
   task automatic test_field_extremes();
      send_append(16'h0000, 64'd10, 64'sh8000_0000_0000_0000, 32'h0000_0000);
      send_append(16'hFFFF, 64'd0, 64'sh7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      send_append(16'h5A5A, '1, -64'sd1, 32'hA5A5_A5A5);
      send_append(16'h0001, 64'd9, 64'sd0, 32'h0000_0001);
      // oldest clock two above mark: incomplete
      send_replay(FUNC_SINCE, 64'd8);
      // oldest clock exactly mark plus one: complete
      send_replay(FUNC_SINCE, 64'd9);
      send_replay(FUNC_SINCE, 64'd0);
      // unbounded mark selects nothing
      send_replay(FUNC_SINCE, '1);
      send_replay(FUNC_SINCE, '1 - 64'd1);
      send_replay(FUNC_ALL, rand64());
      send_item(FUNC_UNUSED, 16'hFFFF, '1, -64'sd1, 32'hFFFF_FFFF, '1);
      send_replay(FUNC_ALL, '0);
      wait_for_idle();
   endtask

   // long receiver hold-off while the sender keeps offering
   task automatic test_output_stall();
      gaps_on         = 1'b0;
      stall_pct       = 0;
      hold_cycles_req = 200;
      repeat (12) send_random_append();
      send_replay(FUNC_ALL, rand64());
      repeat (3) send_random_append();
      wait_for_idle();
   endtask

   // mixed traffic: mostly ordered appends, replays near held clocks
   task automatic test_random_traffic();
      int          issued;
      int          pick;
      int          k;
      int          oldest;
      logic [63:0] mark;
      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         // idling phases: none, light, heavy
         if (issued < 10) begin
            gaps_on   = 1'b0;
            stall_pct = 0;
         end else if (issued < 20) begin
            gaps_on   = 1'b1;
            stall_pct = 30;
         end else begin
            gaps_on   = 1'b1;
            stall_pct = 60;
         end
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            send_item(FUNC_UNUSED, 16'($urandom), rand64(), rand64(), $urandom, rand64());
         end else if (pick < 66) begin
            send_random_append();
            issued++;
         end else if (pick < 88) begin
            k      = $urandom_range(0, 9);
            oldest = (ring_wp + DEPTH - ring_held) % DEPTH;
            if (ring_held != 0 && k < 4) begin
               mark = ring_store[(oldest + $urandom_range(0, ring_held - 1)) % DEPTH].lamport
                      + 64'($urandom_range(0, 3)) - 64'd2;
            end else if (ring_held != 0 && k == 4) begin
               mark = ring_store[oldest].lamport - 64'($urandom_range(0, 3));
            end else if (k == 5) begin
               mark = '1;
            end else if (k == 6) begin
               mark = '1 - 64'd1;
            end else if (k == 7) begin
               mark = '0;
            end else begin
               mark = rand64();
            end
            send_replay(FUNC_SINCE, mark);
            issued++;
         end else begin
            send_replay(FUNC_ALL, rand64());
            issued++;
         end
         if (issued % 15 == 14) begin
            wait_for_idle();
         end
      end
      wait_for_idle();
   endtask

   // overwrite past the depth, then replay the survivors
   task automatic test_ring_wrap();
      int oldest;
      gaps_on   = 1'b0;
      stall_pct = 10;
      repeat (DEPTH + 6) send_random_append();
      send_replay(FUNC_ALL, rand64());
      oldest = (ring_wp + DEPTH - ring_held) % DEPTH;
      send_replay(FUNC_SINCE, ring_store[oldest].lamport - 64'd2);
      send_replay(FUNC_SINCE, ring_store[(ring_wp + DEPTH - 1) % DEPTH].lamport - 64'd1);
      wait_for_idle();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_ring();
      test_field_extremes();
      test_output_stall();
      test_random_traffic();
      test_ring_wrap();
      // drain, then let the block settle after any ignored item
      req_tvalid <= 1'b0;
      while (pending_trace_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DEPTH + 8) @(posedge clock);
      $display("run covered %0d appends, %0d replays and %0d ignored codes",
               n_appends, n_replays, n_ignored);
      $display("%0d result items checked, ring wrapped past its %0d entries",
               results_seen, DEPTH);
      if (mismatch_count == 0 && pending_trace_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(CLK_PERIOD * TIMEOUT_CYCLES);
      $display("timeout with %0d results outstanding", pending_trace_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire
